// ----- src/mlfq_pkg.sv -----
// shared types and constants of the feedback-queue scheduler
package mlfq_pkg;
	localparam int TaskW    = 4;
	localparam int MaxTasks = 16;
	localparam int BurstW   = 16;
	localparam int TimeW    = 32;
	localparam int Levels   = 3;
	localparam int CntW     = 5;

	localparam logic [1:0] REG_QTOP = 2'd0;
	localparam logic [1:0] REG_QMID = 2'd1;
	localparam logic [1:0] REG_QLOW = 2'd2;
	localparam logic [1:0] REG_AGE  = 2'd3;

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef logic [TaskW-1:0] task_t;
	typedef logic [1:0]       lvl_t;

	// queue command from the sequencer to the queue store
	typedef struct packed {
		logic  push;
		logic  pop;
		lvl_t  lvl;
		task_t tsk;
	} qcmd_t;

	// queue status back to the sequencer
	typedef struct packed {
		logic [Levels-1:0] nonempty;
		task_t             head_task;
	} qstat_t;
endpackage

// ----- src/mlfq_queues.sv -----
// three ready queues in one memory, with heads, tails and counts
module mlfq_queues import mlfq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qcmd_t  cmd,
	input  lvl_t   rd_lvl,
	output qstat_t stat
);
	task_t mem [Levels*MaxTasks];
	logic [TaskW-1:0] head_q [Levels];
	logic [TaskW-1:0] tail_q [Levels];
	logic [CntW-1:0]  cnt_q  [Levels];
	task_t            rd_q;
	logic [5:0]       waddr, raddr;

	assign waddr = {cmd.lvl, tail_q[cmd.lvl]};
	assign raddr = {rd_lvl, head_q[rd_lvl]};

	// popped task is held until the next pop
	always_ff @(posedge clk) begin
		if (cmd.push) mem[waddr] <= cmd.tsk;
		if (cmd.pop) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Levels; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (cmd.push) begin
				tail_q[cmd.lvl] <= tail_q[cmd.lvl] + 1'b1;
			end
			if (cmd.pop) begin
				head_q[cmd.lvl] <= head_q[cmd.lvl] + 1'b1;
			end
			for (int i = 0; i < Levels; i++) begin
				if (cmd.push && cmd.lvl == lvl_t'(i) && !(cmd.pop && cmd.lvl == lvl_t'(i)))
					cnt_q[i] <= cnt_q[i] + 1'b1;
				else if (cmd.pop && cmd.lvl == lvl_t'(i) && !(cmd.push && cmd.lvl == lvl_t'(i)))
					cnt_q[i] <= cnt_q[i] - 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < Levels; i++) stat.nonempty[i] = (cnt_q[i] != '0);
		stat.head_task = rd_q;
	end
endmodule

// ----- src/mlfq_scheduler.sv -----
// top level of the three-level feedback-queue scheduler
// Items come in on s_axis: tdata {burst, task_id}, tuser func (0 arrival,
// 1 tick). An arrival makes no result; a tick makes exactly one result on
// m_axis: tdata {time_now, finished, run_level, run_task, ran}.
// Configuration is a plain write port: index 0 quantum_top, 1 quantum_mid,
// 2 quantum_low, 3 age_limit; writes take effect at once, no read-back.
// One item is handled at a time by a small sequencer sharing one queue
// memory (one write and one registered read a cycle) and one subtractor
// for the waiting-time compare. An arrival passes through S_ARR and back
// to idle. A tick passes through S_PRE, then S_RUN while the running task
// carries on, S_FIND and S_RUN when nothing is queued, and S_FIND, S_WAIT,
// S_CHK and S_RUN when a task is dispatched, with S_FIND, S_WAIT and S_CHK
// again for each promotion; the queue memory read sets the steps.
// s_axis_tready is low while an item is in progress or a result waits; the
// next item can be taken in the cycle after the result's transfer.
// A stalled m_axis holds its result and the block takes nothing new
// until it is transferred. Reset clears queues, task state, time and the
// running task, and loads the register defaults; queue slots and
// stamps hold no reset and are only read after being written.
module mlfq_scheduler import mlfq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // task_id[3:0], burst[19:4], zero fill
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // ran, run_task, run_level, finished, time_now
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ARR   = 7'b0000010,
		S_PRE   = 7'b0000100,
		S_FIND  = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_CHK   = 7'b0100000,
		S_RUN   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [7:0]  qtop_q, qmid_q, qlow_q, slice_q;
	logic [15:0] age_q;
	logic [BurstW-1:0] rem_q [MaxTasks];
	logic [TimeW-1:0]  stamp_q [MaxTasks];
	logic [TimeW-1:0]  now_q;
	logic        run_v_q;
	task_t       run_t_q, id_q;
	lvl_t        run_l_q, pop_l_q;
	logic [BurstW-1:0] burst_q;
	logic        out_v_q;
	logic [39:0] out_q;
	qcmd_t       cmd;
	qstat_t      stat;
	lvl_t        rd_lvl;
	logic [TimeW-1:0] waited;
	logic [7:0]  quant;
	logic [BurstW-1:0] rem_next;

	mlfq_queues u_q (.clk, .arst_n, .cmd, .rd_lvl, .stat);

	assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	// highest non-empty level for the pop
	always_comb begin
		if (stat.nonempty[0])      rd_lvl = 2'd0;
		else if (stat.nonempty[1]) rd_lvl = 2'd1;
		else                       rd_lvl = 2'd2;
	end

	// shared subtractor for the wait check
	assign waited = now_q - stamp_q[stat.head_task];
	assign rem_next = rem_q[run_t_q] - 1'b1;

	always_comb begin
		case (run_l_q)
			2'd0:    quant = qtop_q;
			2'd1:    quant = qmid_q;
			default: quant = qlow_q;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_ARR: begin
				if (burst_q != '0 && rem_q[id_q] == '0) begin
					cmd.push = 1'b1;
					cmd.lvl  = 2'd0;
					cmd.tsk  = id_q;
				end
			end
			S_PRE: begin
				if (run_v_q && run_l_q != 2'd0 && stat.nonempty[0]) begin
					cmd.push = 1'b1;
					cmd.lvl  = run_l_q;
					cmd.tsk  = run_t_q;
				end
			end
			S_FIND: begin
				if (stat.nonempty != '0) begin
					cmd.pop = 1'b1;
					cmd.lvl = rd_lvl;
				end
			end
			S_CHK: begin
				if (pop_l_q != 2'd0 && waited >= TimeW'(age_q)) begin
					cmd.push = 1'b1;
					cmd.lvl  = pop_l_q - 1'b1;
					cmd.tsk  = stat.head_task;
				end
			end
			S_RUN: begin
				if (run_v_q && rem_next != '0 && (slice_q + 1'b1) >= quant) begin
					cmd.push = 1'b1;
					cmd.lvl  = (run_l_q == 2'd2) ? 2'd2 : run_l_q + 1'b1;
					cmd.tsk  = run_t_q;
				end
			end
			default: ;
		endcase
	end

	// a push at quantum expiry is stamped with the time after this tick, any other push with the time now
	always_ff @(posedge clk) begin
		if (cmd.push) stamp_q[cmd.tsk] <= (state_q == S_RUN) ? now_q + 1'b1 : now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			qtop_q <= 8'd2; qmid_q <= 8'd4; qlow_q <= 8'd8; age_q <= 16'd10;
			for (int i = 0; i < MaxTasks; i++) rem_q[i] <= '0;
			now_q <= '0; run_v_q <= 1'b0; run_t_q <= '0; run_l_q <= '0;
			slice_q <= '0; out_v_q <= 1'b0; id_q <= '0; burst_q <= '0;
			pop_l_q <= '0; out_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_QTOP: qtop_q <= cfg_data[7:0];
					REG_QMID: qmid_q <= cfg_data[7:0];
					REG_QLOW: qlow_q <= cfg_data[7:0];
					REG_AGE:  age_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						id_q    <= s_axis_tdata[3:0];
						burst_q <= s_axis_tdata[19:4];
						state_q <= (s_axis_tuser == FUNC_TICK) ? S_PRE : S_ARR;
					end
				end
				S_ARR: begin
					if (cmd.push) rem_q[id_q] <= burst_q;
					state_q <= S_IDLE;
				end
				S_PRE: begin
					if (cmd.push) run_v_q <= 1'b0;
					state_q <= (cmd.push || !run_v_q) ? S_FIND : S_RUN;
				end
				S_FIND: begin
					pop_l_q <= rd_lvl;
					state_q <= cmd.pop ? S_WAIT : S_RUN;
				end
				S_WAIT: state_q <= S_CHK;
				S_CHK: begin
					if (cmd.push) begin
						state_q <= S_FIND;
					end else begin
						run_v_q <= 1'b1;
						run_t_q <= stat.head_task;
						run_l_q <= pop_l_q;
						slice_q <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					now_q   <= now_q + 1'b1;
					out_v_q <= 1'b1;
					if (run_v_q) begin
						rem_q[run_t_q] <= rem_next;
						slice_q <= slice_q + 1'b1;
						if (rem_next == '0 || cmd.push) run_v_q <= 1'b0;
						out_q <= {now_q + 1'b1, rem_next == '0, run_l_q, run_t_q, 1'b1};
					end else begin
						out_q <= {now_q + 1'b1, 1'b0, 2'd0, 4'd0, 1'b0};
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !s_axis_tready) else $error("ready while result waits");
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |=> now_q == $past(now_q) + 1'b1) else $error("time step");
	a_runlvl: assert property (@(posedge clk) disable iff (!arst_n)
		run_v_q |-> run_l_q != 2'd3) else $error("bad level");
endmodule
